>>> rtl/tbeq_pkg.sv
// Shared types, constants and helpers for the three-band equaliser.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none
package tbeq_pkg;

   // Fixed arithmetic formats
   localparam int LP_BITS     = 32;   // low-pass state, Q16
   localparam int HP_BITS     = 40;   // high-pass state, Q16
   localparam int DIFF_BITS   = 41;   // high-pass input sum, saturated
   localparam int ALPHA_FRAC  = 16;
   localparam int GAIN_FRAC   = 12;
   localparam int COEF_BITS   = 16;
   localparam int MUL_B_BITS  = 42;   // widest band value (mid)
   localparam int PROD_BITS   = COEF_BITS + 1 + MUL_B_BITS;
   localparam int ACC_BITS    = PROD_BITS + 2;
   localparam int OUT_SHIFT   = ALPHA_FRAC + GAIN_FRAC;

   // Configuration register map
   localparam int CSR_INDEX_BITS = 3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_LOW_ALPHA  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_HIGH_ALPHA = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_LOW   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_MID   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_GAIN_HIGH  = 3'd4;

   localparam logic [COEF_BITS-1:0] LOW_ALPHA_RESET  = 16'd2293;
   localparam logic [COEF_BITS-1:0] HIGH_ALPHA_RESET = 16'd28470;
   localparam logic [COEF_BITS-1:0] GAIN_RESET       = 16'd4096;   // unity, Q4.12

   typedef struct packed {
      logic [COEF_BITS-1:0] low_alpha;
      logic [COEF_BITS-1:0] high_alpha;
      logic [COEF_BITS-1:0] gain_low;
      logic [COEF_BITS-1:0] gain_mid;
      logic [COEF_BITS-1:0] gain_high;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LP_MUL,
      ST_LP_ADD,
      ST_HP_MUL,
      ST_HP_ADD,
      ST_GL_MUL,
      ST_GM_MUL,
      ST_GH_MUL,
      ST_ACC_LAST,
      ST_FINISH
   } ctrl_state_type;

   // Datapath commands, one step per cycle unless the final step holds for the output register
   typedef struct packed {
      logic load;
      logic lp_mul;
      logic lp_add;
      logic hp_mul;
      logic hp_add;
      logic gl_mul;
      logic gm_mul;
      logic gh_mul;
      logic acc_last;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } status_type;

   // Clamp a signed value to a signed field of the given width
   function automatic logic signed [63:0] sat_s64(input logic signed [63:0] v,
                                                  input int unsigned bits);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (bits - 1)) - 64'sd1;
      lo = -hi - 64'sd1;
      if (v > hi) begin
         return hi;
      end else if (v < lo) begin
         return lo;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

>>> rtl/tbeq_csr.sv
// Configuration registers of the equaliser: coefficients and band gains.
// Depends on tbeq_pkg.
`default_nettype none
module tbeq_csr (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tbeq_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [tbeq_pkg::COEF_BITS-1:0]        csr_data,
   output tbeq_pkg::cfg_type                          cfg
);

   tbeq_pkg::cfg_type cfg_ff;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Write the addressed register; drop writes beyond the map
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.low_alpha  <= tbeq_pkg::LOW_ALPHA_RESET;
         cfg_ff.high_alpha <= tbeq_pkg::HIGH_ALPHA_RESET;
         cfg_ff.gain_low   <= tbeq_pkg::GAIN_RESET;
         cfg_ff.gain_mid   <= tbeq_pkg::GAIN_RESET;
         cfg_ff.gain_high  <= tbeq_pkg::GAIN_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            tbeq_pkg::REG_LOW_ALPHA:  cfg_ff.low_alpha  <= csr_data;
            tbeq_pkg::REG_HIGH_ALPHA: cfg_ff.high_alpha <= csr_data;
            tbeq_pkg::REG_GAIN_LOW:   cfg_ff.gain_low   <= csr_data;
            tbeq_pkg::REG_GAIN_MID:   cfg_ff.gain_mid   <= csr_data;
            tbeq_pkg::REG_GAIN_HIGH:  cfg_ff.gain_high  <= csr_data;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

>>> rtl/tbeq_ctrl.sv
// Sequencer of the equaliser: steps one sample through the shared multiplier.
// Depends on tbeq_pkg.
`default_nettype none
module tbeq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire tbeq_pkg::status_type status,
   output tbeq_pkg::cmd_type         cmd
);

   tbeq_pkg::ctrl_state_type state_ff;
   tbeq_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tbeq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and one command per step
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tbeq_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = tbeq_pkg::ST_LP_MUL;
            end
         end
         tbeq_pkg::ST_LP_MUL: begin
            cmd.lp_mul = 1'b1;
            state_in   = tbeq_pkg::ST_LP_ADD;
         end
         tbeq_pkg::ST_LP_ADD: begin
            cmd.lp_add = 1'b1;
            state_in   = tbeq_pkg::ST_HP_MUL;
         end
         tbeq_pkg::ST_HP_MUL: begin
            cmd.hp_mul = 1'b1;
            state_in   = tbeq_pkg::ST_HP_ADD;
         end
         tbeq_pkg::ST_HP_ADD: begin
            cmd.hp_add = 1'b1;
            state_in   = tbeq_pkg::ST_GL_MUL;
         end
         tbeq_pkg::ST_GL_MUL: begin
            cmd.gl_mul = 1'b1;
            state_in   = tbeq_pkg::ST_GM_MUL;
         end
         tbeq_pkg::ST_GM_MUL: begin
            cmd.gm_mul = 1'b1;
            state_in   = tbeq_pkg::ST_GH_MUL;
         end
         tbeq_pkg::ST_GH_MUL: begin
            cmd.gh_mul = 1'b1;
            state_in   = tbeq_pkg::ST_ACC_LAST;
         end
         tbeq_pkg::ST_ACC_LAST: begin
            cmd.acc_last = 1'b1;
            state_in     = tbeq_pkg::ST_FINISH;
         end
         tbeq_pkg::ST_FINISH: begin
            // Hold until the output register is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = tbeq_pkg::ST_IDLE;
            end
         end
         default: state_in = tbeq_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/tbeq_datapath.sv
// Datapath of the equaliser: per-channel filter state, one shared multiplier,
// band accumulator and output register. Depends on tbeq_pkg.
`default_nettype none
module tbeq_datapath #(
   parameter int SAMPLE_BITS = 16,
   parameter int CHANNELS    = 2
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire tbeq_pkg::cmd_type             cmd,
   output tbeq_pkg::status_type               status,
   input  wire tbeq_pkg::cfg_type             cfg,
   input  wire logic signed [SAMPLE_BITS-1:0] req_sample,
   input  wire logic                          req_channel,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [SAMPLE_BITS-1:0]             rsp_sample,
   output logic                               rsp_clipped
);

   localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Per-channel filter state
   logic signed [tbeq_pkg::LP_BITS-1:0] lp_out_ff [CHANNELS];
   logic signed [SAMPLE_BITS-1:0]       hp_in_ff  [CHANNELS];
   logic signed [tbeq_pkg::HP_BITS-1:0] hp_out_ff [CHANNELS];

   // Working registers for the sample in flight
   logic signed [SAMPLE_BITS-1:0]          x_ff;
   logic [CIW-1:0]                         ch_ff;
   logic signed [tbeq_pkg::LP_BITS-1:0]    bigx_ff;
   logic signed [tbeq_pkg::LP_BITS-1:0]    low_ff;
   logic signed [tbeq_pkg::DIFF_BITS-1:0]  diff_ff;
   logic signed [tbeq_pkg::HP_BITS-1:0]    high_ff;
   logic signed [tbeq_pkg::MUL_B_BITS-1:0] mid_ff;
   logic signed [tbeq_pkg::PROD_BITS-1:0]  prod_ff;
   logic signed [tbeq_pkg::ACC_BITS-1:0]   acc_ff;
   logic                                   out_valid_ff;
   logic [SAMPLE_BITS-1:0]                 out_sample_ff;
   logic                                   out_clip_ff;

   // Combinational next values
   logic [CIW-1:0]                         ch_in;
   logic signed [63:0]                     bigx_wide;
   logic signed [tbeq_pkg::LP_BITS-1:0]    lp_prev;
   logic signed [SAMPLE_BITS-1:0]          hp_in_prev;
   logic signed [tbeq_pkg::HP_BITS-1:0]    hp_prev;
   logic signed [63:0]                     low_wide;
   logic signed [63:0]                     diff_wide;
   logic signed [63:0]                     high_wide;
   logic signed [63:0]                     lp_delta;
   logic signed [63:0]                     mid_wide;
   logic signed [tbeq_pkg::ACC_BITS-1:0]   acc_in;
   logic signed [63:0]                     acc_biased;
   logic signed [63:0]                     q_wide;
   logic signed [63:0]                     q_sat;
   logic [tbeq_pkg::COEF_BITS-1:0]         mul_a;
   logic signed [tbeq_pkg::MUL_B_BITS-1:0] mul_b;
   logic signed [tbeq_pkg::PROD_BITS-1:0]  prod_in;

   // Clamp the channel number onto the last channel present
   always_comb begin
      if (32'(req_channel) >= CHANNELS) begin
         ch_in = CIW'(CHANNELS - 1);
      end else begin
         ch_in = CIW'(req_channel);
      end
   end

   assign bigx_wide  = tbeq_pkg::sat_s64(64'(req_sample) <<< 16, tbeq_pkg::LP_BITS);
   assign lp_prev    = lp_out_ff[ch_ff];
   assign hp_in_prev = hp_in_ff[ch_ff];
   assign hp_prev    = hp_out_ff[ch_ff];

   // Filter arithmetic around the multiplier
   assign lp_delta  = 64'(bigx_ff) - 64'(lp_prev);
   assign low_wide  = tbeq_pkg::sat_s64(64'(lp_prev) + 64'(prod_ff >>> tbeq_pkg::ALPHA_FRAC),
                                        tbeq_pkg::LP_BITS);
   assign diff_wide = tbeq_pkg::sat_s64(((64'(x_ff) - 64'(hp_in_prev)) <<< 16) + 64'(hp_prev),
                                        tbeq_pkg::DIFF_BITS);
   assign high_wide = tbeq_pkg::sat_s64(64'(prod_ff >>> tbeq_pkg::ALPHA_FRAC),
                                        tbeq_pkg::HP_BITS);
   assign mid_wide  = 64'(bigx_ff) - 64'(low_ff) - 64'(high_ff);
   assign acc_in    = acc_ff + tbeq_pkg::ACC_BITS'(prod_ff);

   // Truncate the weighted sum toward zero, then clamp to the sample range
   always_comb begin
      acc_biased = 64'(acc_ff);
      if (acc_ff < 0) begin
         acc_biased = acc_biased + ((64'sd1 <<< tbeq_pkg::OUT_SHIFT) - 64'sd1);
      end
      q_wide = acc_biased >>> tbeq_pkg::OUT_SHIFT;
      q_sat  = tbeq_pkg::sat_s64(q_wide, SAMPLE_BITS);
   end

   // Select multiplier operands for the current step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (cmd.lp_mul) begin
         mul_a = cfg.low_alpha;
         mul_b = lp_delta[tbeq_pkg::MUL_B_BITS-1:0];
      end else if (cmd.hp_mul) begin
         mul_a = cfg.high_alpha;
         mul_b = tbeq_pkg::MUL_B_BITS'(diff_ff);
      end else if (cmd.gl_mul) begin
         mul_a = cfg.gain_low;
         mul_b = tbeq_pkg::MUL_B_BITS'(low_ff);
      end else if (cmd.gm_mul) begin
         mul_a = cfg.gain_mid;
         mul_b = mid_ff;
      end else if (cmd.gh_mul) begin
         mul_a = cfg.gain_high;
         mul_b = tbeq_pkg::MUL_B_BITS'(high_ff);
      end
   end

   assign prod_in = $signed({1'b0, mul_a}) * mul_b;

   // Filter state: cleared at reset, updated once per sample
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            lp_out_ff[i] <= '0;
            hp_in_ff[i]  <= '0;
            hp_out_ff[i] <= '0;
         end
      end else begin
         if (cmd.lp_add) begin
            lp_out_ff[ch_ff] <= low_wide[tbeq_pkg::LP_BITS-1:0];
         end
         if (cmd.hp_add) begin
            hp_in_ff[ch_ff]  <= x_ff;
            hp_out_ff[ch_ff] <= high_wide[tbeq_pkg::HP_BITS-1:0];
         end
      end
   end

   // Working registers of the sample in flight
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= req_sample;
         ch_ff   <= ch_in;
         bigx_ff <= bigx_wide[tbeq_pkg::LP_BITS-1:0];
      end
      if (cmd.lp_mul || cmd.hp_mul || cmd.gl_mul || cmd.gm_mul || cmd.gh_mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.lp_add) begin
         low_ff  <= low_wide[tbeq_pkg::LP_BITS-1:0];
         diff_ff <= diff_wide[tbeq_pkg::DIFF_BITS-1:0];
      end
      if (cmd.hp_add) begin
         high_ff <= high_wide[tbeq_pkg::HP_BITS-1:0];
      end
      if (cmd.gl_mul) begin
         mid_ff <= mid_wide[tbeq_pkg::MUL_B_BITS-1:0];
         acc_ff <= '0;
      end else if (cmd.gm_mul || cmd.gh_mul || cmd.acc_last) begin
         acc_ff <= acc_in;
      end
   end

   // Output register: hold the result until the receiver takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_sample_ff <= q_sat[SAMPLE_BITS-1:0];
         out_clip_ff   <= (q_sat != q_wide);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_sample      = out_sample_ff;
   assign rsp_clipped     = out_clip_ff;
   assign status.out_busy = out_valid_ff && !rsp_ready;

endmodule
`default_nettype wire

>>> rtl/three_band_equalizer.sv
// Three-band one-pole crossover equaliser, top level.
// Instantiates tbeq_csr, tbeq_ctrl and tbeq_datapath; depends on tbeq_pkg.
//
// Usage:
//   req_*  : input stream, one signed sample per transaction, channel in tuser.
//   rsp_*  : result stream, one equalised sample per input, clip flag in tuser.
//   csr_*  : register writes (index 0 low_alpha, 1 high_alpha, 2 gain_low,
//            3 gain_mid, 4 gain_high); always ready, other indexes ignored.
// Timing:
//   A sample is taken in the idle state and steps through the multiply, add
//   and accumulate states; its result is loaded into the output register at
//   the same edge at which req_tready rises again, and no new sample is taken
//   before then. The pace is set by the single 17 x 42 bit multiplier, used
//   five times per sample, with a register after each product.
// Reset:
//   Synchronous, active high. Clears the filter state of all channels,
//   restores the register defaults and empties the output register.
// Back-pressure:
//   A finished result waits in the output register while the next sample is
//   processed; the sequencer holds at its final step while that result is
//   still waiting and rsp_tready is low.
`default_nettype none
module three_band_equalizer #(
   parameter int SAMPLE_BITS = 16,
   parameter int CHANNELS    = 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,   // sample_in
   input  wire logic                                req_tuser,   // channel
   // Result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]         rsp_tdata,   // sample_out
   output logic                                     rsp_tuser,   // clipped
   // Register writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tbeq_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [tbeq_pkg::COEF_BITS-1:0]      csr_data
);

   localparam int TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

   tbeq_pkg::cfg_type    cfg;
   tbeq_pkg::cmd_type    cmd;
   tbeq_pkg::status_type status;
   logic [SAMPLE_BITS-1:0] rsp_sample;

   tbeq_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   tbeq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tbeq_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .CHANNELS    (CHANNELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .cfg         (cfg),
      .req_sample  ($signed(req_tdata[SAMPLE_BITS-1:0])),
      .req_channel (req_tuser),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_sample  (rsp_sample),
      .rsp_clipped (rsp_tuser)
   );

   // Zero-fill the result up to whole bytes
   assign rsp_tdata = TDATA_BITS'(rsp_sample);

endmodule
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the three-band equaliser (three_band_equalizer).
// Drives sample and register streams, predicts each output in fixed point and
// compares it field by field; depends on tbeq_pkg and the RTL only.
module tb_top;

   localparam int SAMPLE_BITS     = 16;
   localparam int REG_COUNT       = 5;
   localparam int PHASES          = 10;
   localparam int ITEMS_PER_PHASE = 58;
   localparam int SETTLE_CYCLES   = 16;
   localparam logic [tbeq_pkg::COEF_BITS-1:0] COEF_MAX   = 16'hffff;
   localparam logic [tbeq_pkg::COEF_BITS-1:0] COEF_ZERO  = 16'h0000;
   localparam logic [tbeq_pkg::COEF_BITS-1:0] COEF_UNITY = tbeq_pkg::GAIN_RESET;

   // One equalised sample as it leaves the block
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          clip;
   } eq_out_type;

   // Directed stimulus row; the gains apply to that row and those after it
   typedef struct packed {
      logic [tbeq_pkg::COEF_BITS-1:0] gain_low;
      logic [tbeq_pkg::COEF_BITS-1:0] gain_mid;
      logic [tbeq_pkg::COEF_BITS-1:0] gain_high;
      logic signed [SAMPLE_BITS-1:0]  sample;
      logic                           ch;
      logic                           typed;
      logic signed [SAMPLE_BITS-1:0]  want;
      logic                           want_clip;
   } dir_row_type;

   // With all three gains equal the bands sum back to the input, so the
   // output is simply input times gain: those rows carry their answer.
   localparam dir_row_type DIRECTED_ROWS [25] = '{
      // unity gains: output follows input on both channels
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sd0,      1'b0, 1'b1, 16'sd0,      1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sd32767,  1'b0, 1'b1, 16'sd32767,  1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sh8000,   1'b0, 1'b1, 16'sh8000,   1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sd32767,  1'b1, 1'b1, 16'sd32767,  1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sh8000,   1'b1, 1'b1, 16'sh8000,   1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sd1,      1'b0, 1'b1, 16'sd1,      1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, -16'sd1,     1'b1, 1'b1, -16'sd1,     1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sd21845,  1'b0, 1'b1, 16'sd21845,  1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, -16'sd21846, 1'b1, 1'b1, -16'sd21846, 1'b0},
      '{COEF_UNITY, COEF_UNITY, COEF_UNITY, 16'sd0,      1'b1, 1'b1, 16'sd0,      1'b0},
      // zero gains silence everything
      '{COEF_ZERO, COEF_ZERO, COEF_ZERO, 16'sd32767, 1'b0, 1'b1, 16'sd0, 1'b0},
      '{COEF_ZERO, COEF_ZERO, COEF_ZERO, 16'sh8000,  1'b1, 1'b1, 16'sd0, 1'b0},
      // full-scale gains: truncation toward zero and saturation at both rails
      '{COEF_MAX, COEF_MAX, COEF_MAX, 16'sd0,     1'b0, 1'b1, 16'sd0,      1'b0},
      '{COEF_MAX, COEF_MAX, COEF_MAX, 16'sd1,     1'b0, 1'b1, 16'sd15,     1'b0},
      '{COEF_MAX, COEF_MAX, COEF_MAX, -16'sd1,    1'b1, 1'b1, -16'sd15,    1'b0},
      '{COEF_MAX, COEF_MAX, COEF_MAX, 16'sd2048,  1'b0, 1'b1, 16'sd32767,  1'b0},
      '{COEF_MAX, COEF_MAX, COEF_MAX, 16'sd2049,  1'b1, 1'b1, 16'sd32767,  1'b1},
      '{COEF_MAX, COEF_MAX, COEF_MAX, -16'sd2048, 1'b0, 1'b1, -16'sd32767, 1'b0},
      '{COEF_MAX, COEF_MAX, COEF_MAX, -16'sd2049, 1'b1, 1'b1, 16'sh8000,   1'b1},
      '{COEF_MAX, COEF_MAX, COEF_MAX, 16'sd32767, 1'b1, 1'b1, 16'sd32767,  1'b1},
      '{COEF_MAX, COEF_MAX, COEF_MAX, 16'sh8000,  1'b0, 1'b1, 16'sh8000,   1'b1},
      // mid band removed: the filters show through, checked by prediction
      '{COEF_MAX, COEF_ZERO, COEF_MAX, 16'sd32767, 1'b0, 1'b0, 16'sd0, 1'b0},
      '{COEF_MAX, COEF_ZERO, COEF_MAX, 16'sh8000,  1'b0, 1'b0, 16'sd0, 1'b0},
      '{COEF_MAX, COEF_ZERO, COEF_MAX, 16'sd12345, 1'b1, 1'b0, 16'sd0, 1'b0},
      '{COEF_MAX, COEF_ZERO, COEF_MAX, -16'sd1,    1'b1, 1'b0, 16'sd0, 1'b0}
   };

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [SAMPLE_BITS-1:0]              req_tdata = '0;   // sample_in
   logic                                req_tuser = 1'b0; // channel
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0]              rsp_tdata;        // sample_out
   logic                                rsp_tuser;        // clipped
   logic                                csr_valid = 1'b0;
   logic                                csr_ready;
   logic [tbeq_pkg::CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [tbeq_pkg::COEF_BITS-1:0]      csr_data = '0;

   // Register copy and per-channel filter history of the predictor
   tbeq_pkg::cfg_type eq_regs = '{tbeq_pkg::LOW_ALPHA_RESET, tbeq_pkg::HIGH_ALPHA_RESET,
                                  tbeq_pkg::GAIN_RESET, tbeq_pkg::GAIN_RESET,
                                  tbeq_pkg::GAIN_RESET};
   longint  lp_hist [2];
   longint  hp_in_hist [2];
   longint  hp_out_hist [2];

   eq_out_type pending_out [$];
   int         mismatch_count = 0;
   bit         tx_calm = 1'b0;
   bit         rx_calm = 1'b0;

   three_band_equalizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Limit a value to a signed field of the given width
   function automatic longint clamp_signed(input longint v, input int bits);
      longint top;
      top = (longint'(1) <<< (bits - 1)) - 1;
      if (v > top) begin
         return top;
      end else if (v < -top - 1) begin
         return -top - 1;
      end
      return v;
   endfunction

   // Run one sample through both filters, mix the bands and advance the history
   function automatic eq_out_type equalise(input logic signed [SAMPLE_BITS-1:0] s,
                                           input logic ch);
      longint     a_lo, a_hi, g_lo, g_mid, g_hi;
      longint     x, big_x, low, diff, high, mid, acc, q;
      eq_out_type r;
      a_lo  = eq_regs.low_alpha;
      a_hi  = eq_regs.high_alpha;
      g_lo  = eq_regs.gain_low;
      g_mid = eq_regs.gain_mid;
      g_hi  = eq_regs.gain_high;
      x     = s;
      big_x = clamp_signed(x <<< tbeq_pkg::ALPHA_FRAC, tbeq_pkg::LP_BITS);
      // low-pass: floor of the scaled step, i.e. arithmetic shift
      low = lp_hist[ch] + ((a_lo * (big_x - lp_hist[ch])) >>> tbeq_pkg::ALPHA_FRAC);
      low = clamp_signed(low, tbeq_pkg::LP_BITS);
      // high-pass feeds back its own last output
      diff = ((x - hp_in_hist[ch]) <<< tbeq_pkg::ALPHA_FRAC) + hp_out_hist[ch];
      diff = clamp_signed(diff, tbeq_pkg::DIFF_BITS);
      high = clamp_signed((a_hi * diff) >>> tbeq_pkg::ALPHA_FRAC, tbeq_pkg::HP_BITS);
      lp_hist[ch]     = low;
      hp_in_hist[ch]  = x;
      hp_out_hist[ch] = high;
      mid = big_x - low - high;
      acc = low * g_lo + mid * g_mid + high * g_hi;
      // truncate toward zero, then saturate
      q = (acc >= 0) ? (acc >>> tbeq_pkg::OUT_SHIFT) : -((-acc) >>> tbeq_pkg::OUT_SHIFT);
      r.clip   = (clamp_signed(q, SAMPLE_BITS) != q);
      q        = clamp_signed(q, SAMPLE_BITS);
      r.sample = q[SAMPLE_BITS-1:0];
      return r;
   endfunction

   // Write one register; valid stays high for a following write
   task automatic write_reg(input logic [tbeq_pkg::CSR_INDEX_BITS-1:0] idx,
                            input logic [tbeq_pkg::COEF_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         tbeq_pkg::REG_LOW_ALPHA:  eq_regs.low_alpha  = value;
         tbeq_pkg::REG_HIGH_ALPHA: eq_regs.high_alpha = value;
         tbeq_pkg::REG_GAIN_LOW:   eq_regs.gain_low   = value;
         tbeq_pkg::REG_GAIN_MID:   eq_regs.gain_mid   = value;
         tbeq_pkg::REG_GAIN_HIGH:  eq_regs.gain_high  = value;
         default: ;
      endcase
   endtask

   // Program a full register set, poking the unused indexes first
   task automatic load_settings(input tbeq_pkg::cfg_type cfg);
      int idx;
      for (idx = REG_COUNT; idx < (1 << tbeq_pkg::CSR_INDEX_BITS); idx++) begin
         write_reg(tbeq_pkg::CSR_INDEX_BITS'(idx), tbeq_pkg::COEF_BITS'($urandom));
      end
      write_reg(tbeq_pkg::REG_LOW_ALPHA, cfg.low_alpha);
      write_reg(tbeq_pkg::REG_HIGH_ALPHA, cfg.high_alpha);
      write_reg(tbeq_pkg::REG_GAIN_LOW, cfg.gain_low);
      write_reg(tbeq_pkg::REG_GAIN_MID, cfg.gain_mid);
      write_reg(tbeq_pkg::REG_GAIN_HIGH, cfg.gain_high);
      csr_valid <= 1'b0;
   endtask

   // Drop valid and hold until every expected result has come back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
   endtask

   // Offer one sample after a random gap; queue its expectation on acceptance
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] s, input logic ch,
                              input eq_out_type want, input bit drain);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 19);
      if (drain) begin
         if (gap == 0) gap = 1;
         drain_results();
      end else if (gap > 0) begin
         req_tvalid <= 1'b0;
      end
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tuser  <= ch;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_out.push_back(want);
   endtask

   // Register settings per random phase, extremes first
   function automatic tbeq_pkg::cfg_type phase_settings(input int phase);
      tbeq_pkg::cfg_type c;
      c.low_alpha  = tbeq_pkg::COEF_BITS'($urandom);
      c.high_alpha = tbeq_pkg::COEF_BITS'($urandom);
      c.gain_low   = tbeq_pkg::COEF_BITS'($urandom_range(0, 8192));
      c.gain_mid   = tbeq_pkg::COEF_BITS'($urandom_range(0, 8192));
      c.gain_high  = tbeq_pkg::COEF_BITS'($urandom_range(0, 8192));
      case (phase)
         0: begin
            c.low_alpha  = COEF_ZERO;
            c.high_alpha = COEF_ZERO;
         end
         1: begin
            c.low_alpha  = COEF_MAX;
            c.high_alpha = COEF_MAX;
         end
         2: begin
            c.low_alpha  = COEF_MAX;
            c.high_alpha = COEF_ZERO;
         end
         3: begin
            c.gain_low  = COEF_MAX;
            c.gain_mid  = COEF_ZERO;
            c.gain_high = COEF_MAX;
         end
         4: begin
            c.gain_low  = COEF_ZERO;
            c.gain_mid  = COEF_MAX;
            c.gain_high = COEF_ZERO;
         end
         5: c = '0;
         6: c = '1;
         7: c.gain_mid = tbeq_pkg::COEF_BITS'($urandom);
         default: ;
      endcase
      return c;
   endfunction

   // Compare each result with the oldest expectation
   always @(posedge clock) begin : check_results
      eq_out_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_out.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected result: sample %0d clip %0b",
                        $signed(rsp_tdata), rsp_tuser);
            end
         end else begin
            want = pending_out.pop_front();
            if (rsp_tdata !== want.sample || rsp_tuser !== want.clip) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch: expected sample %0d clip %0b, got sample %0d clip %0b",
                           want.sample, want.clip, $signed(rsp_tdata), rsp_tuser);
               end
            end
         end
      end
   end

   // Accept results with random stalls and calm stretches
   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
         stall = rx_calm ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   initial begin : stimulus
      dir_row_type                   d;
      tbeq_pkg::cfg_type             cfg;
      eq_out_type                    want;
      logic signed [SAMPLE_BITS-1:0] s;
      logic signed [SAMPLE_BITS-1:0] ramp_pos [2];
      bit                            square_hi [2];
      logic                          ch;
      int                            row, phase, n, pause_at;
      ramp_pos[0]  = '0;
      ramp_pos[1]  = '0;
      square_hi[0] = 1'b0;
      square_hi[1] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed table; reprogram gains whenever a row changes them
      for (row = 0; row < 25; row++) begin
         d = DIRECTED_ROWS[row];
         if (row == 0 || d.gain_low != eq_regs.gain_low ||
             d.gain_mid != eq_regs.gain_mid || d.gain_high != eq_regs.gain_high) begin
            drain_results();
            cfg           = eq_regs;
            cfg.gain_low  = d.gain_low;
            cfg.gain_mid  = d.gain_mid;
            cfg.gain_high = d.gain_high;
            load_settings(cfg);
         end
         want = equalise(d.sample, d.ch);
         if (d.typed) begin
            want.sample = d.want;
            want.clip   = d.want_clip;
         end
         send_sample(d.sample, d.ch, want, 1'b0);
      end

      // Random phases, each with its own settings and one full drain inside
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         load_settings(phase_settings(phase));
         tx_calm  = ($urandom_range(0, 3) == 0);
         pause_at = $urandom_range(0, ITEMS_PER_PHASE - 1);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            ch = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
               0, 1, 2: s = SAMPLE_BITS'($urandom);
               3: begin
                  case ($urandom_range(0, 4))
                     0: s = 16'sd32767;
                     1: s = 16'sh8000;
                     2: s = 16'sd0;
                     3: s = 16'sd1;
                     default: s = -16'sd1;
                  endcase
               end
               4, 5: begin
                  // full-scale square wave stresses the high-pass
                  square_hi[ch] = !square_hi[ch];
                  s = square_hi[ch] ? 16'sd32767 : 16'sh8000;
               end
               6, 7: begin
                  // sawtooth lets the low-pass track and lag
                  ramp_pos[ch] = ramp_pos[ch] + SAMPLE_BITS'($urandom_range(0, 2047));
                  s = ramp_pos[ch];
               end
               default: begin
                  s = SAMPLE_BITS'($urandom_range(0, 127));
                  s = s - 16'sd64;
               end
            endcase
            want = equalise(s, ch);
            send_sample(s, ch, want, n == pause_at);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_out.size() != 0) mismatch_count++;
      if (mismatch_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run
   initial begin : watchdog
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

>>> files.f
rtl/tbeq_pkg.sv
rtl/tbeq_csr.sv
rtl/tbeq_ctrl.sv
rtl/tbeq_datapath.sv
rtl/three_band_equalizer.sv
tb/tb_top.sv
